// ----- design/cbc_pkg.sv -----
package cbc_pkg;

    localparam int RAM_BANKS_MAX  = 4;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int ROM_BANK_BYTES = 16384;

    localparam int RAM_DEPTH   = RAM_BANKS_MAX * RAM_BANK_BYTES;
    localparam int RAM_ADDR_W  = $clog2(RAM_DEPTH);
    localparam int RAM_OFS_W   = $clog2(RAM_BANK_BYTES);
    localparam int RAM_BANK_W  = 2;
    localparam int BANK_CNT_W  = 3;
    localparam int ROM_OFS_W   = $clog2(ROM_BANK_BYTES);
    localparam int ROM_BANK_W  = 7;
    localparam int ROM_ADDR_W  = 21;
    localparam int ROM_SIZE_W  = 22;
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAPPER_ENABLED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROM_SIZE_BYTES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BANK_COUNT = 2'd2;

    localparam logic [ROM_SIZE_W-1:0] ROM_SIZE_RESET   = 22'd32768;
    localparam logic [DATA_W-1:0]     OPEN_BUS         = 8'hFF;
    localparam logic [3:0]            RAM_ENABLE_KEY   = 4'hA;
    localparam logic [2:0]            RAM_WINDOW_TOP   = 3'b101;

    localparam logic [1:0] CTRL_RAM_ENABLE = 2'd0;
    localparam logic [1:0] CTRL_ROM_LOW    = 2'd1;
    localparam logic [1:0] CTRL_BANK_HIGH  = 2'd2;
    localparam logic [1:0] CTRL_MODE       = 2'd3;

    typedef enum logic [1:0] {
        OP_DIRECT    = 2'd0,
        OP_RAM_READ  = 2'd1,
        OP_RAM_WRITE = 2'd2
    } op_kind_t;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] write_byte;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0]     read_byte;
        logic                  data_source;
        logic [ROM_ADDR_W-1:0] rom_fetch_address;
    } rsp_t;

    typedef struct packed {
        op_kind_t              kind;
        logic [RAM_ADDR_W-1:0] ram_addr;
        logic [DATA_W-1:0]     write_byte;
        logic                  data_source;
        logic [ROM_ADDR_W-1:0] rom_fetch_address;
    } op_t;

endpackage

// ----- design/cbc_ram.sv -----
module cbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/cbc_fifo.sv -----
module cbc_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cbc_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output cbc_pkg::op_t  head_op
);
    import cbc_pkg::*;

    op_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_op   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ----- design/cbc_front.sv -----
module cbc_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  cbc_pkg::req_t                    s_req,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cbc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             clearing,
    input  logic                             queue_full,
    output logic                             push,
    output cbc_pkg::op_t                     push_op
);
    import cbc_pkg::*;

    logic                  mapper_en_reg;
    logic [ROM_SIZE_W-1:0] rom_size_reg;
    logic [BANK_CNT_W-1:0] bank_cnt_reg;
    logic [ROM_BANK_W-1:0] rom_bank_reg, rom_bank_next;
    logic [RAM_BANK_W-1:0] ram_bank_reg, ram_bank_next;
    logic                  ram_en_reg, ram_en_next;
    logic                  rom_mode_reg, rom_mode_next;

    logic [BANK_CNT_W-1:0] banks_avail;
    logic                  ram_ok;
    logic                  in_ram_window;
    logic [ROM_ADDR_W-1:0] rom_addr;
    logic [4:0]            low_bits;
    logic                  ctrl_write;

    assign s_ready   = !queue_full && !clearing;
    assign cfg_ready = 1'b1;
    assign push      = s_valid && s_ready;

    assign banks_avail   = (bank_cnt_reg > BANK_CNT_W'(RAM_BANKS_MAX))
                         ? BANK_CNT_W'(RAM_BANKS_MAX) : bank_cnt_reg;
    assign ram_ok        = ram_en_reg && (banks_avail != '0)
                         && ({1'b0, ram_bank_reg} < banks_avail);
    assign in_ram_window = (s_req.bus_address[ADDR_W-1:RAM_OFS_W] == RAM_WINDOW_TOP);
    assign rom_addr      = s_req.bus_address[ROM_OFS_W]
                         ? {rom_bank_reg, s_req.bus_address[ROM_OFS_W-1:0]}
                         : ROM_ADDR_W'(s_req.bus_address[ROM_OFS_W-1:0]);
    assign low_bits      = (s_req.write_byte[4:0] == 5'd0) ? 5'd1 : s_req.write_byte[4:0];
    assign ctrl_write    = push && s_req.req_type && !s_req.bus_address[ADDR_W-1]
                         && mapper_en_reg;

    always_comb begin
        push_op                   = '0;
        push_op.kind              = OP_DIRECT;
        push_op.ram_addr          = {ram_bank_reg, s_req.bus_address[RAM_OFS_W-1:0]};
        push_op.write_byte        = s_req.write_byte;
        if (!s_req.bus_address[ADDR_W-1]) begin
            if (!s_req.req_type && ({1'b0, rom_addr} < rom_size_reg)) begin
                push_op.data_source       = 1'b1;
                push_op.rom_fetch_address = rom_addr;
            end
        end else if (in_ram_window && ram_ok) begin
            push_op.kind = s_req.req_type ? OP_RAM_WRITE : OP_RAM_READ;
        end
    end

    always_comb begin
        rom_bank_next = rom_bank_reg;
        ram_bank_next = ram_bank_reg;
        ram_en_next   = ram_en_reg;
        rom_mode_next = rom_mode_reg;
        if (ctrl_write) begin
            case (s_req.bus_address[ROM_OFS_W:RAM_OFS_W])
                CTRL_RAM_ENABLE: begin
                    ram_en_next = (s_req.write_byte[3:0] == RAM_ENABLE_KEY);
                end
                CTRL_ROM_LOW: begin
                    rom_bank_next = {rom_bank_reg[6:5], low_bits};
                end
                CTRL_BANK_HIGH: begin
                    if (rom_mode_reg) begin
                        rom_bank_next = {s_req.write_byte[1:0], rom_bank_reg[4:0]};
                    end else begin
                        ram_bank_next = s_req.write_byte[1:0];
                    end
                end
                CTRL_MODE: begin
                    rom_mode_next = !s_req.write_byte[0];
                end
                default: begin
                    rom_mode_next = rom_mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mapper_en_reg <= 1'b1;
            rom_size_reg  <= ROM_SIZE_RESET;
            bank_cnt_reg  <= '0;
            rom_bank_reg  <= ROM_BANK_W'(1);
            ram_bank_reg  <= '0;
            ram_en_reg    <= 1'b0;
            rom_mode_reg  <= 1'b1;
        end else begin
            rom_bank_reg <= rom_bank_next;
            ram_bank_reg <= ram_bank_next;
            ram_en_reg   <= ram_en_next;
            rom_mode_reg <= rom_mode_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MAPPER_ENABLED: mapper_en_reg <= cfg_data[0];
                    CFG_ROM_SIZE_BYTES: rom_size_reg  <= cfg_data[ROM_SIZE_W-1:0];
                    CFG_RAM_BANK_COUNT: bank_cnt_reg  <= cfg_data[BANK_CNT_W-1:0];
                    default:            bank_cnt_reg  <= bank_cnt_reg;
                endcase
            end
        end
    end

endmodule

// ----- design/cbc_back.sv -----
module cbc_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_not_empty,
    input  cbc_pkg::op_t  q_head,
    output logic          q_pop,
    output logic          clearing,
    output logic          m_valid,
    input  logic          m_ready,
    output cbc_pkg::rsp_t m_rsp
);
    import cbc_pkg::*;

    logic                  clr_busy_reg;
    logic [RAM_ADDR_W-1:0] clr_cnt_reg;
    logic                  out_valid_reg, out_valid_next;
    op_kind_t              out_kind_reg;
    logic                  out_src_reg;
    logic [ROM_ADDR_W-1:0] out_fetch_reg;

    logic                  ram_we, ram_re;
    logic [RAM_ADDR_W-1:0] ram_addr;
    logic [DATA_W-1:0]     ram_wdata, ram_rdata;

    assign clearing = clr_busy_reg;
    assign q_pop    = q_not_empty && !clr_busy_reg && (!out_valid_reg || m_ready);

    assign ram_we    = clr_busy_reg || (q_pop && (q_head.kind == OP_RAM_WRITE));
    assign ram_re    = q_pop && (q_head.kind == OP_RAM_READ);
    assign ram_addr  = clr_busy_reg ? clr_cnt_reg : q_head.ram_addr;
    assign ram_wdata = clr_busy_reg ? '0 : q_head.write_byte;

    cbc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (q_pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (clr_busy_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1) begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_kind_reg  <= q_head.kind;
            out_src_reg   <= q_head.data_source;
            out_fetch_reg <= q_head.rom_fetch_address;
        end
    end

    assign m_valid                 = out_valid_reg;
    assign m_rsp.read_byte         = (out_kind_reg == OP_RAM_READ) ? ram_rdata : OPEN_BUS;
    assign m_rsp.data_source       = out_src_reg;
    assign m_rsp.rom_fetch_address = out_fetch_reg;

`ifndef SYNTHESIS
    a_no_pop_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !q_pop)
        else $error("queue popped during RAM clearing");

    a_rdata_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> $stable(ram_rdata))
        else $error("RAM read data changed under a stalled result");

    a_clear_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clr_busy_reg) |-> (clr_cnt_reg == '0))
        else $error("RAM clearing ended before covering every entry");

    a_direct_open_bus: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_src_reg) |-> (out_kind_reg == OP_DIRECT))
        else $error("ROM fetch result tagged as a RAM access");
`endif

endmodule

// ----- design/cartridge_bank_controller_core.sv -----
// Cartridge bank controller of the MBC1 kind: one bus request in, one result out, one request
// per cycle sustained while m_ready is high and clearing is over; a request is registered in the
// queue, then in the output register. The front end decodes requests against the bank
// registers and issues them into a two-entry queue; the back end performs the single-port
// cartridge RAM access and holds the result in an output register. After reset the 32768-byte
// cartridge RAM is cleared one byte per cycle with s_ready low; config writes still go through.
module cartridge_bank_controller_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  cbc_pkg::req_t                    s_req,
    output logic                             m_valid,
    input  logic                             m_ready,
    output cbc_pkg::rsp_t                    m_rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cbc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cbc_pkg::*;

    logic clearing;
    logic q_full, q_push, q_pop, q_not_empty;
    op_t  q_in, q_head;

    cbc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .clearing   (clearing),
        .queue_full (q_full),
        .push       (q_push),
        .push_op    (q_in)
    );

    cbc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_op   (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_op   (q_head)
    );

    cbc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rsp       (m_rsp)
    );

endmodule
